>>> rtl/ale_pkg.sv
// Shared constants and types for the array list engine.
// Used by ale_ctrl, ale_dp and array_list_engine; no dependencies.
package ale_pkg;

   localparam int ALE_DEPTH = 256;
   localparam int CAP_W     = 9;
   localparam int CW        = 13;   // compare width, holds any length up to 4096
   localparam int POS_W     = 8;
   localparam int WORD_W    = 32;
   localparam int ACT_W     = 4;
   localparam int ST_W      = 2;
   localparam int CNT_W     = 9;
   localparam int REQ_W     = 48;
   localparam int RSP_W     = 56;

   localparam logic [ACT_W-1:0] ACT_APPEND  = 4'd0;
   localparam logic [ACT_W-1:0] ACT_INSERT  = 4'd1;
   localparam logic [ACT_W-1:0] ACT_DELETE  = 4'd2;
   localparam logic [ACT_W-1:0] ACT_GET     = 4'd3;
   localparam logic [ACT_W-1:0] ACT_SET     = 4'd4;
   localparam logic [ACT_W-1:0] ACT_SEARCH  = 4'd5;
   localparam logic [ACT_W-1:0] ACT_STRANS  = 4'd6;
   localparam logic [ACT_W-1:0] ACT_SHEAD   = 4'd7;
   localparam logic [ACT_W-1:0] ACT_BSEARCH = 4'd8;
   localparam logic [ACT_W-1:0] ACT_SINSERT = 4'd9;

   localparam logic [ST_W-1:0] ST_OK      = 2'd0;
   localparam logic [ST_W-1:0] ST_FULL    = 2'd1;
   localparam logic [ST_W-1:0] ST_BAD_POS = 2'd2;
   localparam logic [ST_W-1:0] ST_MISS    = 2'd3;

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_START = 6'b000010,
      S_READ  = 6'b000100,
      S_EVAL  = 6'b001000,
      S_SWAP  = 6'b010000,
      S_DONE  = 6'b100000
   } state_type;

   typedef struct packed {
      logic load;
      logic start;
      logic read;
      logic eval;
      logic swap;
      logic publish;
   } cmd_type;

   typedef struct packed {
      logic fin;
      logic go_swap;
   } sts_type;

endpackage

>>> rtl/ale_ctrl.sv
// Sequencer for the array list engine: request intake, phase stepping,
// result register valid. Depends on ale_pkg.
module ale_ctrl import ale_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   output logic    rsp_tvalid,
   input  logic    rsp_tready,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      cmd         = '0;
      cmd.load    = (state_ff == S_IDLE) && req_tvalid;
      cmd.start   = (state_ff == S_START);
      cmd.read    = (state_ff == S_READ);
      cmd.eval    = (state_ff == S_EVAL);
      cmd.swap    = (state_ff == S_SWAP);
      cmd.publish = (state_ff == S_DONE) && slot_free;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) state_in = S_START;
         end
         S_START: begin
            state_in = sts.fin ? S_DONE : S_READ;
         end
         S_READ: begin
            state_in = S_EVAL;
         end
         S_EVAL: begin
            if (sts.fin)          state_in = S_DONE;
            else if (sts.go_swap) state_in = S_SWAP;
            else                  state_in = S_READ;
         end
         S_SWAP: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (slot_free) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.publish)     rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
      else                 rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> rtl/ale_dp.sv
// Datapath for the array list engine: entry memory, length, walk
// counters and result register. Depends on ale_pkg.
module ale_dp import ale_pkg::*; #(
   parameter int DEPTH = ALE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [REQ_W-1:0] req_tdata,
   input  logic [CAP_W-1:0] capacity,
   input  cmd_type          cmd,
   output sts_type          sts,
   output logic [RSP_W-1:0] rsp_tdata
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LW = $clog2(DEPTH + 1);
   localparam logic [LW-1:0] ONE = 1;
   localparam logic [CW-1:0] ONE_C = 1;

   logic [WORD_W-1:0] mem [DEPTH];

   logic [LW-1:0]     len_ff, len_in;
   logic [LW-1:0]     idx_ff, idx_in;
   logic [LW-1:0]     lo_ff, lo_in;
   logic [LW-1:0]     hi_ff, hi_in;
   logic              swp_ff, swp_in;
   logic [ACT_W-1:0]  act_ff;
   logic [POS_W-1:0]  pos_ff;
   logic [WORD_W-1:0] key_ff;
   logic [ST_W-1:0]   st_ff, st_in;
   logic [WORD_W-1:0] wo_ff, wo_in;
   logic [POS_W-1:0]  po_ff, po_in;
   logic [WORD_W-1:0] rdata_ff;
   logic [RSP_W-1:0]  rsp_ff;

   logic              we, rd_en;
   logic [AW-1:0]     wa, ra;
   logic [WORD_W-1:0] wd;
   logic [CW-1:0]     len_c, pos_c, idx_c, bound_c;
   logic              full, bad_pos, gt, eq;
   logic [LW:0]       mid_w;
   logic [LW-1:0]     mid;

   assign len_c   = CW'(len_ff);
   assign pos_c   = CW'(pos_ff);
   assign idx_c   = CW'(idx_ff);
   assign bound_c = (CW'(capacity) < CW'(DEPTH)) ? CW'(capacity) : CW'(DEPTH);
   assign full    = len_c >= bound_c;
   assign bad_pos = pos_c >= len_c;
   assign gt      = $signed(rdata_ff) > $signed(key_ff);
   assign eq      = rdata_ff == key_ff;
   assign mid_w   = ({1'b0, lo_ff} + {1'b0, hi_ff} - {{LW{1'b0}}, 1'b1}) >> 1;
   assign mid     = mid_w[LW-1:0];

   always_comb begin
      len_in = len_ff;
      idx_in = idx_ff;
      lo_in  = lo_ff;
      hi_in  = hi_ff;
      swp_in = swp_ff;
      st_in  = st_ff;
      wo_in  = wo_ff;
      po_in  = po_ff;
      we     = 1'b0;
      wa     = AW'(idx_ff);
      wd     = key_ff;
      rd_en  = 1'b0;
      ra     = AW'(idx_ff);
      sts    = '0;

      if (cmd.start) begin
         st_in  = ST_OK;
         wo_in  = '0;
         po_in  = '0;
         swp_in = 1'b0;
         case (act_ff)
            ACT_APPEND: begin
               sts.fin = 1'b1;
               if (full) begin
                  st_in = ST_FULL;
               end else begin
                  we     = 1'b1;
                  wa     = AW'(len_ff);
                  po_in  = POS_W'(len_ff);
                  len_in = len_ff + ONE;
               end
            end
            ACT_INSERT: begin
               if (full) begin
                  st_in = ST_FULL; sts.fin = 1'b1;
               end else if (bad_pos) begin
                  st_in = ST_BAD_POS; sts.fin = 1'b1;
               end else begin
                  idx_in = len_ff;
               end
            end
            ACT_DELETE, ACT_GET: begin
               if (bad_pos) begin
                  st_in = ST_BAD_POS; sts.fin = 1'b1;
               end else begin
                  idx_in = LW'(pos_ff);
               end
            end
            ACT_SET: begin
               sts.fin = 1'b1;
               if (bad_pos) begin
                  st_in = ST_BAD_POS;
               end else begin
                  we    = 1'b1;
                  wa    = AW'(pos_ff);
                  po_in = pos_ff;
               end
            end
            ACT_SEARCH, ACT_STRANS, ACT_SHEAD: begin
               idx_in = '0;
               if (len_ff == '0) begin
                  st_in = ST_MISS; sts.fin = 1'b1;
               end
            end
            ACT_BSEARCH: begin
               lo_in = '0;
               hi_in = len_ff;
               if (len_ff == '0) begin
                  st_in = ST_MISS; sts.fin = 1'b1;
               end
            end
            ACT_SINSERT: begin
               if (full) begin
                  st_in = ST_FULL; sts.fin = 1'b1;
               end else if (len_ff == '0) begin
                  we      = 1'b1;
                  wa      = '0;
                  len_in  = len_ff + ONE;
                  sts.fin = 1'b1;
               end else begin
                  idx_in = len_ff;
               end
            end
            default: begin
               sts.fin = 1'b1;
            end
         endcase
      end

      if (cmd.read) begin
         rd_en = 1'b1;
         case (act_ff)
            ACT_INSERT, ACT_SINSERT: ra = AW'(idx_ff - ONE);
            ACT_BSEARCH:             ra = AW'(mid);
            default:                 ra = AW'(idx_ff);
         endcase
      end

      if (cmd.eval) begin
         case (act_ff)
            ACT_INSERT: begin
               we     = 1'b1;
               wd     = rdata_ff;
               idx_in = idx_ff - ONE;
               if (CW'(idx_ff - ONE) == pos_c) sts.go_swap = 1'b1;
            end
            ACT_DELETE: begin
               // first read fetches the removed word, later ones move down
               if (idx_c == pos_c) begin
                  wo_in = rdata_ff;
               end else begin
                  we = 1'b1;
                  wa = AW'(idx_ff - ONE);
                  wd = rdata_ff;
               end
               idx_in = idx_ff + ONE;
               if (idx_c + ONE_C >= len_c) begin
                  po_in   = pos_ff;
                  len_in  = len_ff - ONE;
                  sts.fin = 1'b1;
               end
            end
            ACT_GET: begin
               wo_in   = rdata_ff;
               po_in   = pos_ff;
               sts.fin = 1'b1;
            end
            ACT_SEARCH, ACT_STRANS, ACT_SHEAD: begin
               if (swp_ff) begin
                  // partner word moves to the hit slot, key goes to partner
                  we          = 1'b1;
                  wa          = AW'(hi_ff);
                  wd          = rdata_ff;
                  sts.go_swap = 1'b1;
               end else if (eq) begin
                  po_in = POS_W'(idx_ff);
                  if ((act_ff == ACT_STRANS && idx_ff != '0) || act_ff == ACT_SHEAD) begin
                     swp_in = 1'b1;
                     hi_in  = idx_ff;
                     idx_in = (act_ff == ACT_STRANS) ? idx_ff - ONE : '0;
                  end else begin
                     sts.fin = 1'b1;
                  end
               end else begin
                  idx_in = idx_ff + ONE;
                  if (idx_c + ONE_C >= len_c) begin
                     st_in = ST_MISS; sts.fin = 1'b1;
                  end
               end
            end
            ACT_BSEARCH: begin
               if (eq) begin
                  po_in   = POS_W'(mid);
                  sts.fin = 1'b1;
               end else if (gt) begin
                  hi_in = mid;
                  if (lo_ff >= mid) begin
                     st_in = ST_MISS; sts.fin = 1'b1;
                  end
               end else begin
                  lo_in = mid + ONE;
                  if ({1'b0, mid} + {{LW{1'b0}}, 1'b1} >= {1'b0, hi_ff}) begin
                     st_in = ST_MISS; sts.fin = 1'b1;
                  end
               end
            end
            ACT_SINSERT: begin
               we = 1'b1;
               if (gt) begin
                  wd     = rdata_ff;
                  idx_in = idx_ff - ONE;
                  if (idx_ff == ONE) sts.go_swap = 1'b1;
               end else begin
                  po_in   = POS_W'(idx_ff);
                  len_in  = len_ff + ONE;
                  sts.fin = 1'b1;
               end
            end
            default: begin
               sts.fin = 1'b1;
            end
         endcase
      end

      if (cmd.swap) begin
         we = 1'b1;
         if (act_ff == ACT_INSERT || act_ff == ACT_SINSERT) begin
            po_in  = POS_W'(idx_ff);
            len_in = len_ff + ONE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (we) mem[wa] <= wd;
      if (rd_en) rdata_ff <= mem[ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
      end else begin
         len_ff <= len_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      swp_ff <= swp_in;
      st_ff  <= st_in;
      wo_ff  <= wo_in;
      po_ff  <= po_in;
      if (cmd.load) begin
         act_ff <= req_tdata[ACT_W-1:0];
         pos_ff <= req_tdata[ACT_W +: POS_W];
         key_ff <= req_tdata[ACT_W+POS_W +: WORD_W];
      end
      if (cmd.publish) begin
         rsp_ff <= {{(RSP_W-ST_W-WORD_W-POS_W-CNT_W){1'b0}},
                    CNT_W'(len_ff), po_ff, wo_ff, st_ff};
      end
   end

   assign rsp_tdata = rsp_ff;

endmodule

>>> rtl/array_list_engine.sv
// Usage notes for array_list_engine:
// Holds a packed list of signed 32-bit entries with a live length capped
// by the capacity register (min of capacity and DEPTH).
// req channel: one word per operation (action, position_in, word_in).
// rsp channel: one word per operation (status, word_out, position_out,
// count), in request order.
// csr channel: writes capacity; write it only while no operation is open.
// Append, set and refused operations finish without an entry read; get
// reads one entry. Insert, delete, linear search and sorted insert step
// through the entry memory one entry moved or compared at a time (one
// read, then one write/compare); binary search reads and compares one
// entry per probe. One operation is in flight at a time.
// The entry memory has a registered read.
// A finished result sits in an output register; a new request is taken
// while it waits. If rsp_tready stays low the engine holds its next
// result until the register frees.
// Reset clears the length to zero and capacity to 256; entry contents
// are left as they are.
module array_list_engine import ale_pkg::*; #(
   parameter int DEPTH = ALE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,   // action[3:0], position_in[11:4], word_in[43:12]
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata,   // status[1:0], word_out[33:2],
                                         // position_out[41:34], count[50:42]
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [CAP_W-1:0] csr_data     // capacity
);

   logic [CAP_W-1:0] cap_ff;
   cmd_type          cmd;
   sts_type          sts;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_W'(256);
      end else if (csr_valid) begin
         cap_ff <= csr_data;
      end
   end

   ale_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   ale_dp #(.DEPTH(DEPTH)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .capacity  (cap_ff),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_tdata (rsp_tdata)
   );

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (32'(rsp_tdata[50:42]) <= 32'(DEPTH)))
      else $error("count above depth");

   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second word taken while busy");

   a_fail_no_pos: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[1:0] != ST_OK) |-> (rsp_tdata[41:34] == '0))
      else $error("position on failed operation");

   a_fail_no_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[1:0] != ST_OK) |-> (rsp_tdata[33:2] == '0))
      else $error("word on failed operation");

endmodule

>>> tb/testbench.sv
// Self-checking testbench for array_list_engine: directed table, then random phases
// over several capacity settings, checked against an in-file list predictor.
// Depends on ale_pkg and the array_list_engine RTL.
`timescale 1ns / 1ps
module testbench;
   import ale_pkg::*;

   localparam int          LIST_DEPTH = ALE_DEPTH;
   localparam int          LIMIT      = 3_000_000;
   localparam logic [3:0]  ACT_UNUSED_LO = 4'd10;
   localparam logic [3:0]  ACT_UNUSED_HI = 4'd15;
   localparam logic [31:0] W_MIN = 32'h8000_0000;
   localparam logic [31:0] W_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] W_NEG1 = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [ST_W-1:0]   status;
      logic [WORD_W-1:0] word;
      logic [POS_W-1:0]  pos;
      logic [CNT_W-1:0]  count;
   } list_result_t;

   typedef struct {
      logic [ACT_W-1:0]  act;
      logic [POS_W-1:0]  pos;
      logic [WORD_W-1:0] word;
      bit                typed;
      list_result_t      want;
   } op_row_t;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [RSP_W-1:0] rsp_tdata;
   logic csr_valid = 0;
   logic csr_ready;
   logic [CAP_W-1:0] csr_data = '0;

   // predictor state
   logic [WORD_W-1:0] list_mem [LIST_DEPTH];
   int unsigned       list_len = 0;
   int unsigned       list_cap = 256;

   list_result_t pending_results [$];
   bit           cur_typed = 0;
   list_result_t cur_want;
   int unsigned  n_sent = 0;
   int unsigned  n_cycles = 0;
   int unsigned  n_errors = 0;
   bit           hold_done = 0;

   array_list_engine u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   function automatic list_result_t list_apply(logic [ACT_W-1:0] act, logic [POS_W-1:0] pos,
                                               logic [WORD_W-1:0] w);
      list_result_t r;
      int unsigned  i, lo, hi, mid, lim;
      logic [WORD_W-1:0] t;
      r = '0;
      lim = (list_cap < LIST_DEPTH) ? list_cap : LIST_DEPTH;
      case (act)
         ACT_APPEND: begin
            if (list_len >= lim) r.status = ST_FULL;
            else begin
               list_mem[list_len] = w;
               r.pos = POS_W'(list_len);
               list_len++;
            end
         end
         ACT_INSERT: begin
            if (list_len >= lim) r.status = ST_FULL;
            else if (pos >= list_len) r.status = ST_BAD_POS;
            else begin
               for (i = list_len; i > pos; i--) list_mem[i] = list_mem[i-1];
               list_mem[pos] = w;
               r.pos = pos;
               list_len++;
            end
         end
         ACT_DELETE: begin
            if (pos >= list_len) r.status = ST_BAD_POS;
            else begin
               r.word = list_mem[pos];
               for (i = pos; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
               r.pos = pos;
               list_len--;
            end
         end
         ACT_GET: begin
            if (pos >= list_len) r.status = ST_BAD_POS;
            else begin
               r.word = list_mem[pos];
               r.pos = pos;
            end
         end
         ACT_SET: begin
            if (pos >= list_len) r.status = ST_BAD_POS;
            else begin
               list_mem[pos] = w;
               r.pos = pos;
            end
         end
         ACT_SEARCH, ACT_STRANS, ACT_SHEAD: begin
            r.status = ST_MISS;
            for (i = 0; i < list_len; i++) begin
               if (list_mem[i] == w) begin
                  r.status = ST_OK;
                  r.pos = POS_W'(i);
                  // hit at the head: transposition has nothing to swap with
                  if (act == ACT_STRANS && i > 0) begin
                     t = list_mem[i]; list_mem[i] = list_mem[i-1]; list_mem[i-1] = t;
                  end else if (act == ACT_SHEAD) begin
                     t = list_mem[i]; list_mem[i] = list_mem[0]; list_mem[0] = t;
                  end
                  break;
               end
            end
         end
         ACT_BSEARCH: begin
            r.status = ST_MISS;
            lo = 0;
            hi = list_len;
            while (lo < hi) begin
               mid = (lo + hi - 1) >> 1;
               if (list_mem[mid] == w) begin
                  r.status = ST_OK;
                  r.pos = POS_W'(mid);
                  break;
               end
               if ($signed(list_mem[mid]) > $signed(w)) hi = mid;
               else lo = mid + 1;
            end
         end
         ACT_SINSERT: begin
            if (list_len >= lim) r.status = ST_FULL;
            else begin
               i = list_len;
               while (i > 0 && $signed(list_mem[i-1]) > $signed(w)) begin
                  list_mem[i] = list_mem[i-1];
                  i--;
               end
               list_mem[i] = w;
               r.pos = POS_W'(i);
               list_len++;
            end
         end
         default: ;
      endcase
      r.count = CNT_W'(list_len);
      return r;
   endfunction

   // accept side: predict on each request word, check each response word
   always @(posedge clock) begin
      list_result_t got, want, pred;
      if (!reset) begin
         n_cycles <= n_cycles + 1;
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[50:0];
            got.status = rsp_tdata[1:0];
            got.word   = rsp_tdata[33:2];
            got.pos    = rsp_tdata[41:34];
            got.count  = rsp_tdata[50:42];
            if (pending_results.size() == 0) begin
               $error("response word with nothing pending");
               n_errors++;
            end else begin
               want = pending_results.pop_front();
               if (got.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, got.status);
                  n_errors++;
               end
               if (got.word !== want.word) begin
                  $error("word_out: expected %h, got %h", want.word, got.word);
                  n_errors++;
               end
               if (got.pos !== want.pos) begin
                  $error("position_out: expected %0d, got %0d", want.pos, got.pos);
                  n_errors++;
               end
               if (got.count !== want.count) begin
                  $error("count: expected %0d, got %0d", want.count, got.count);
                  n_errors++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            pred = list_apply(req_tdata[3:0], req_tdata[11:4], req_tdata[43:12]);
            pending_results.push_back(cur_typed ? cur_want : pred);
            n_sent <= n_sent + 1;
         end
         if (csr_valid && csr_ready) list_cap = 32'(csr_data);
      end
   end

   always @(posedge clock) begin
      if (n_cycles > LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // receiver: random stalls, one long hold-off, one quiet stretch
   always @(negedge clock) begin
      int unsigned hold_left;
      if (reset) begin
         rsp_tready <= 0;
         hold_left = 0;
      end else if (hold_left > 0) begin
         rsp_tready <= 0;
         hold_left--;
      end else if (!hold_done && n_sent >= 120) begin
         hold_done = 1;
         hold_left = 600;
         rsp_tready <= 0;
      end else if (n_sent >= 350 && n_sent < 450) begin
         rsp_tready <= 1;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= 22);
      end
   end

   task automatic send_op(logic [ACT_W-1:0] act, logic [POS_W-1:0] pos,
                          logic [WORD_W-1:0] w, bit typed, list_result_t want);
      if (!(n_sent >= 350 && n_sent < 450)) begin
         while ($urandom_range(0, 99) < 22) begin
            req_tvalid <= 0;
            @(negedge clock);
         end
      end
      req_tdata  <= {4'b0, w, pos, act};
      cur_typed  <= typed;
      cur_want   <= want;
      req_tvalid <= 1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic drain_all();
      req_tvalid <= 0;
      wait (pending_results.size() == 0);
      repeat (2 * LIST_DEPTH + 20) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_capacity(logic [CAP_W-1:0] value);
      csr_data  <= value;
      csr_valid <= 1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 0;
   endtask

   function automatic logic [WORD_W-1:0] pick_word();
      case ($urandom_range(0, 5))
         0: return W_MIN;
         1: return W_MAX;
         2, 3: return $urandom_range(0, 15) - 8;
         default: return $urandom;
      endcase
   endfunction

   op_row_t directed [] = '{
      '{ACT_GET,     8'd0,   32'd0,      1, '{ST_BAD_POS, 32'd0, 8'd0, 9'd0}},
      '{ACT_DELETE,  8'd0,   32'd0,      1, '{ST_BAD_POS, 32'd0, 8'd0, 9'd0}},
      '{ACT_SEARCH,  8'd0,   32'd5,      1, '{ST_MISS,    32'd0, 8'd0, 9'd0}},
      '{ACT_BSEARCH, 8'd0,   32'd5,      1, '{ST_MISS,    32'd0, 8'd0, 9'd0}},
      '{ACT_APPEND,  8'd255, W_MIN,      1, '{ST_OK,      32'd0, 8'd0, 9'd1}},
      '{ACT_APPEND,  8'd0,   W_MAX,      1, '{ST_OK,      32'd0, 8'd1, 9'd2}},
      '{ACT_INSERT,  8'd2,   32'd1,      1, '{ST_BAD_POS, 32'd0, 8'd0, 9'd2}},
      '{ACT_INSERT,  8'd0,   32'd0,      1, '{ST_OK,      32'd0, 8'd0, 9'd3}},
      '{ACT_GET,     8'd1,   32'd0,      1, '{ST_OK,      W_MIN, 8'd1, 9'd3}},
      '{ACT_SET,     8'd2,   W_NEG1,     1, '{ST_OK,      32'd0, 8'd2, 9'd3}},
      '{ACT_STRANS,  8'd0,   32'd0,      1, '{ST_OK,      32'd0, 8'd0, 9'd3}},
      '{ACT_STRANS,  8'd0,   W_MIN,      1, '{ST_OK,      32'd0, 8'd1, 9'd3}},
      '{ACT_SHEAD,   8'd0,   W_NEG1,     1, '{ST_OK,      32'd0, 8'd2, 9'd3}},
      '{ACT_SEARCH,  8'd0,   32'd12345,  1, '{ST_MISS,    32'd0, 8'd0, 9'd3}},
      '{ACT_DELETE,  8'd2,   32'd0,      1, '{ST_OK,      W_MIN, 8'd2, 9'd2}},
      '{ACT_BSEARCH, 8'd0,   32'd0,      0, '0},
      '{ACT_SINSERT, 8'd0,   32'd5,      0, '0},
      '{ACT_SINSERT, 8'd0,   W_MIN,      0, '0},
      '{ACT_BSEARCH, 8'd0,   32'd5,      0, '0},
      '{ACT_UNUSED_HI, 8'd7, W_NEG1,     1, '{ST_OK,      32'd0, 8'd0, 9'd4}},
      '{ACT_UNUSED_LO, 8'd0, 32'd9,      1, '{ST_OK,      32'd0, 8'd0, 9'd4}},
      '{ACT_GET,     8'd255, 32'd0,      1, '{ST_BAD_POS, 32'd0, 8'd0, 9'd4}},
      '{ACT_DELETE,  8'd0,   32'd0,      0, '0}
   };

   // capacity, item count, append and delete weights per random phase
   int phase_cap   [] = '{3, 1, 0, 16, 256, 511, 2};
   int phase_items [] = '{60, 30, 20, 80, 200, 150, 60};
   int phase_wapp  [] = '{30, 30, 30, 35, 55, 70, 10};
   int phase_wdel  [] = '{15, 40, 10, 15, 10, 5, 70};

   initial begin
      logic [ACT_W-1:0]  act;
      logic [POS_W-1:0]  pos;
      logic [WORD_W-1:0] w;
      int unsigned       r, n_rand;
      n_rand = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      foreach (directed[k])
         send_op(directed[k].act, directed[k].pos, directed[k].word,
                 directed[k].typed, directed[k].want);
      foreach (phase_cap[p]) begin
         drain_all();
         write_capacity(CAP_W'(phase_cap[p]));
         for (int n = 0; n < phase_items[p]; n++) begin
            if (n_rand == 250) drain_all();
            n_rand++;
            r = $urandom_range(0, 99);
            if (r < phase_wapp[p]) act = ACT_APPEND;
            else if (r < phase_wapp[p] + phase_wdel[p]) act = ACT_DELETE;
            else if (r < 97) act = ACT_W'($urandom_range(ACT_INSERT, ACT_SINSERT));
            else act = ACT_W'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
            if ($urandom_range(0, 9) == 0 || list_len == 0)
               pos = POS_W'($urandom_range(0, 255));
            else
               pos = POS_W'($urandom_range(0, list_len));
            if (list_len > 0 && $urandom_range(0, 1))
               w = list_mem[$urandom_range(0, list_len - 1)];
            else
               w = pick_word();
            send_op(act, pos, w, 0, '0);
         end
      end
      drain_all();
      if (pending_results.size() != 0) n_errors++;
      if (n_errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
